FILE: rtl/patterned_line_pixel_generator_top_macros.svh
// Assertion helpers, clocked on clk and held off during rst
`ifndef PATTERNED_LINE_PIXEL_GENERATOR_TOP_MACROS_SVH
`define PATTERNED_LINE_PIXEL_GENERATOR_TOP_MACROS_SVH

// same-cycle implication
`define PLG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PLG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/plgen_pkg.sv
`timescale 1ns / 1ps

package plgen_pkg;

  localparam int COORD_BITS   = 12;
  localparam int COLOR_BITS   = 16;
  localparam int PATTERN_BITS = 32;
  localparam int PANEL_BITS   = 11;
  localparam int ORIENT_BITS  = 2;
  localparam int SPAN_BITS    = COORD_BITS + 1;
  localparam int DEC_BITS     = COORD_BITS + 4;
  localparam int MAP_BITS     = COORD_BITS + 2;
  localparam int PIDX_BITS    = $clog2(PATTERN_BITS);
  localparam int CFG_IDX_BITS = 2;

  localparam logic [CFG_IDX_BITS-1:0] CFG_ORIENTATION  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PANEL_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PANEL_HEIGHT = 2'd2;

  localparam logic [ORIENT_BITS-1:0] ORIENT_0   = 2'd0;
  localparam logic [ORIENT_BITS-1:0] ORIENT_90  = 2'd1;
  localparam logic [ORIENT_BITS-1:0] ORIENT_180 = 2'd2;
  localparam logic [ORIENT_BITS-1:0] ORIENT_270 = 2'd3;

  localparam logic FUNC_START   = 1'b0;
  localparam logic FUNC_ADVANCE = 1'b1;

  localparam logic [ORIENT_BITS-1:0] ORIENT_RESET       = ORIENT_0;
  localparam logic [PANEL_BITS-1:0]  PANEL_WIDTH_RESET  = 11'd128;
  localparam logic [PANEL_BITS-1:0]  PANEL_HEIGHT_RESET = 11'd64;

  typedef struct packed {
    logic                          func;
    logic signed [COORD_BITS-1:0]  x_start;
    logic signed [COORD_BITS-1:0]  y_start;
    logic signed [COORD_BITS-1:0]  x_end;
    logic signed [COORD_BITS-1:0]  y_end;
    logic        [COLOR_BITS-1:0]  line_color;
    logic        [PATTERN_BITS-1:0] dash_pattern;
  } in_beat_t;

  typedef struct packed {
    logic                  produced;
    logic                  write_pixel;
    logic [PANEL_BITS-1:0] pixel_x;
    logic [PANEL_BITS-1:0] pixel_y;
    logic [COLOR_BITS-1:0] pixel_color;
    logic                  last;
  } out_beat_t;

endpackage

FILE: rtl/patterned_line_pixel_generator_top.sv
// The result beat is registered and appears in the cycle after its input beat is accepted.
// Throughput: 1 beat per cycle unless a stalled valid output raises in_stall; line state and
// the pixel mapping are combinational logic between the state registers and the output register.
// Reset (rst, synchronous): no line active, output empty, orientation 0,
// panel 128 x 64.
`timescale 1ns / 1ps
`include "patterned_line_pixel_generator_top_macros.svh"

module patterned_line_pixel_generator_top
  import plgen_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [PANEL_BITS-1:0]   cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  in_beat_t                in_data,
  output logic                    out_valid,
  input  logic                    out_stall,
  output out_beat_t               out_data
);

  localparam logic signed [COORD_BITS-1:0] ONE_C = COORD_BITS'(1);
  localparam logic signed [MAP_BITS-1:0]   ONE_M = MAP_BITS'(1);

  logic [ORIENT_BITS-1:0] orientation;
  logic [PANEL_BITS-1:0]  panel_width;
  logic [PANEL_BITS-1:0]  panel_height;

  logic                           active;
  logic signed [COORD_BITS-1:0]   cur_x, cur_y, target_x, target_y;
  logic signed [DEC_BITS-1:0]     decision;
  logic        [SPAN_BITS-1:0]    twice_abs_dx, twice_abs_dy;
  logic                           step_x_negative, step_y_negative, x_major;
  logic        [PATTERN_BITS-1:0] held_pattern;
  logic        [PIDX_BITS-1:0]    pattern_index;
  logic        [COLOR_BITS-1:0]   held_color;

  logic in_acc;
  logic is_start, is_adv;

  // start-side terms
  logic signed [SPAN_BITS-1:0]  dx, dy, ndx, ndy;
  logic        [COORD_BITS-1:0] adx, ady;
  logic        [SPAN_BITS-1:0]  tadx, tady;
  logic                         xmaj_start;
  logic signed [DEC_BITS-1:0]   dec_start;

  // advance-side terms
  logic                         draw, is_last, on_panel;
  logic signed [MAP_BITS-1:0]   cx, cy, wv, hv, px, py;
  logic signed [COORD_BITS-1:0] cur_x_step, cur_y_step;
  logic signed [DEC_BITS-1:0]   tdx_d, tdy_d, dec_minor, dec_next;
  logic                         minor_step;
  logic [PIDX_BITS-1:0]         pattern_index_next;

  out_beat_t res;

  assign in_stall = out_valid & out_stall;
  assign in_acc   = in_valid & ~in_stall;
  assign is_start = in_data.func == FUNC_START;
  assign is_adv   = in_data.func == FUNC_ADVANCE;

  always_ff @(posedge clk) begin
    if (rst) begin
      orientation  <= ORIENT_RESET;
      panel_width  <= PANEL_WIDTH_RESET;
      panel_height <= PANEL_HEIGHT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_ORIENTATION:  orientation  <= cfg_data[ORIENT_BITS-1:0];
        CFG_PANEL_WIDTH:  panel_width  <= cfg_data;
        CFG_PANEL_HEIGHT: panel_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    dx   = SPAN_BITS'(in_data.x_end) - SPAN_BITS'(in_data.x_start);
    dy   = SPAN_BITS'(in_data.y_end) - SPAN_BITS'(in_data.y_start);
    ndx  = -dx;
    ndy  = -dy;
    adx  = dx[SPAN_BITS-1] ? ndx[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
    ady  = dy[SPAN_BITS-1] ? ndy[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
    tadx = {adx, 1'b0};
    tady = {ady, 1'b0};
    xmaj_start = tadx > tady;
    if (xmaj_start) begin
      dec_start = signed'(DEC_BITS'(tady)) - signed'(DEC_BITS'(adx));
    end else begin
      dec_start = signed'(DEC_BITS'(tadx)) - signed'(DEC_BITS'(ady));
    end
  end

  always_comb begin
    draw    = held_pattern[pattern_index];
    is_last = x_major ? (cur_x == target_x) : (cur_y == target_y);
    cx = MAP_BITS'(cur_x);
    cy = MAP_BITS'(cur_y);
    wv = signed'(MAP_BITS'(panel_width));
    hv = signed'(MAP_BITS'(panel_height));
    case (orientation)
      ORIENT_0: begin
        px = cx;
        py = cy;
      end
      ORIENT_90: begin
        px = wv - cy - ONE_M;
        py = cx;
      end
      ORIENT_180: begin
        px = wv - cx - ONE_M;
        py = hv - cy - ONE_M;
      end
      default: begin
        px = cy;
        py = hv - cx - ONE_M;
      end
    endcase
    on_panel = (px >= 0) && (py >= 0) && (px < wv) && (py < hv);

    cur_x_step = step_x_negative ? cur_x - ONE_C : cur_x + ONE_C;
    cur_y_step = step_y_negative ? cur_y - ONE_C : cur_y + ONE_C;
    tdx_d      = signed'(DEC_BITS'(twice_abs_dx));
    tdy_d      = signed'(DEC_BITS'(twice_abs_dy));
    minor_step = decision >= 0;
    if (x_major) begin
      dec_minor = minor_step ? decision - tdx_d : decision;
      dec_next  = dec_minor + tdy_d;
    end else begin
      dec_minor = minor_step ? decision - tdy_d : decision;
      dec_next  = dec_minor + tdx_d;
    end

    if (pattern_index == PIDX_BITS'(PATTERN_BITS - 1)) begin
      pattern_index_next = '0;
    end else begin
      pattern_index_next = pattern_index + PIDX_BITS'(1);
    end

    res = '0;
    if (is_adv && active) begin
      res.produced = 1'b1;
      res.last     = is_last;
      if (draw && on_panel) begin
        res.write_pixel = 1'b1;
        res.pixel_x     = px[PANEL_BITS-1:0];
        res.pixel_y     = py[PANEL_BITS-1:0];
        res.pixel_color = held_color;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active          <= 1'b0;
      cur_x           <= '0;
      cur_y           <= '0;
      target_x        <= '0;
      target_y        <= '0;
      decision        <= '0;
      twice_abs_dx    <= '0;
      twice_abs_dy    <= '0;
      step_x_negative <= 1'b0;
      step_y_negative <= 1'b0;
      x_major         <= 1'b0;
      held_pattern    <= '0;
      pattern_index   <= '0;
      held_color      <= '0;
    end else if (in_acc) begin
      if (is_start) begin
        active          <= 1'b1;
        cur_x           <= in_data.x_start;
        cur_y           <= in_data.y_start;
        target_x        <= in_data.x_end;
        target_y        <= in_data.y_end;
        decision        <= dec_start;
        twice_abs_dx    <= tadx;
        twice_abs_dy    <= tady;
        step_x_negative <= dx[SPAN_BITS-1];
        step_y_negative <= dy[SPAN_BITS-1];
        x_major         <= xmaj_start;
        held_pattern    <= in_data.dash_pattern;
        pattern_index   <= '0;
        held_color      <= in_data.line_color;
      end else if (active) begin
        pattern_index <= pattern_index_next;
        if (is_last) begin
          active <= 1'b0;
        end else begin
          decision <= dec_next;
          if (x_major) begin
            cur_x <= cur_x_step;
            if (minor_step) begin
              cur_y <= cur_y_step;
            end
          end else begin
            cur_y <= cur_y_step;
            if (minor_step) begin
              cur_x <= cur_x_step;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_acc) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data <= res;
    end
  end

  `PLG_ASSERT_NOW(a_write_needs_point, out_valid && out_data.write_pixel, out_data.produced, "pixel write without a produced point")
  `PLG_ASSERT_NOW(a_idle_result_clear, out_valid && !out_data.produced, !out_data.last && !out_data.write_pixel, "idle result carries flags")
  `PLG_ASSERT_NEXT(a_start_arms_line, in_acc && is_start, active && pattern_index == '0, "start beat did not arm the line")
  `PLG_ASSERT_NEXT(a_end_drops_line, in_acc && is_adv && active && is_last, !active && out_valid && out_data.last, "end point did not close the line")

endmodule
